// File: hdl/psi_pkg.sv
// Shared types and constants of the pulse-shaping interpolator.
// Request and sample structs for both channels, command codes, default sizes.
// No dependencies.
package psi_pkg;

  localparam int SPS_DEF    = 8;
  localparam int SPAN_DEF   = 4;
  localparam int IDX_W      = 6;
  localparam int SAMPLE_W   = 16;

  typedef enum logic {
    CMD_TAP_WRITE = 1'b0,
    CMD_SYMBOL    = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                        command;
    logic [IDX_W-1:0]            tap_index;
    logic signed [SAMPLE_W-1:0]  tap_value;
    logic signed [SAMPLE_W-1:0]  sym_i;
    logic signed [SAMPLE_W-1:0]  sym_q;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  out_i;
    logic signed [SAMPLE_W-1:0]  out_q;
    logic                        last;
  } out_item_t;

endpackage

// File: hdl/pulse_shaping_interpolator_unit.sv
// Top level of the pulse-shaping interpolator: banked tap store, symbol
// history, phase sequencer and a four-stage MAC / round / saturate pipeline.
// Depends on psi_pkg.

// Interpolating pulse-shaping FIR for complex Q1.15 symbols. A request with
// command CMD_TAP_WRITE loads one Q1.15 tap (index >= SPS*SPAN+1 is dropped)
// and yields no sample; a CMD_SYMBOL request shifts the symbol into a
// SPAN+1 deep history and yields SPS complex samples, one per cycle unless
// out_stall holds the pipeline, the last one flagged. Every tap that a
// symbol uses must be loaded first. The phase sequencer issues one output
// phase per cycle while the pipeline is not stalled; the next request
// (symbol or tap write) is taken in the cycle the last phase of the current
// symbol issues, so the stream runs with no gap. The first sample of a
// symbol passes the history, bank read, product, sum and output registers.
// The tap store is SPAN+1 banks of SPS words, one per history lane, so all
// taps of one phase are read together; it needs no clearing after reset.
module pulse_shaping_interpolator_unit #(
  parameter int SPS  = psi_pkg::SPS_DEF,
  parameter int SPAN = psi_pkg::SPAN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  psi_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output psi_pkg::out_item_t  out_item
);

  localparam int NTAPS  = SPS * SPAN + 1;
  localparam int LANES  = SPAN + 1;
  localparam int PW     = $clog2(SPS);
  localparam int KW_RAW = $clog2(LANES * SPS + 1);
  localparam int KW     = (KW_RAW > psi_pkg::IDX_W + 1) ? KW_RAW : psi_pkg::IDX_W + 1;
  localparam int DW     = psi_pkg::SAMPLE_W;
  localparam int PROD_W = 2 * DW;
  localparam int SUM_W  = PROD_W + $clog2(LANES);
  localparam int QW     = SUM_W - 15;
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);
  // signed zero keeps the lane product a signed multiply
  localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

  // Q5.30 sum (at SPAN = 4) -> round half up at bit 15 -> saturate to Q1.15
  function automatic logic signed [DW-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W-1:0] rnd;
    logic signed [QW-1:0]    quo;
    rnd = acc + SUM_W'(16384);
    quo = rnd[SUM_W-1:15];
    if (quo > QMAX) begin
      round_sat = QMAX[DW-1:0];
    end else if (quo < QMIN) begin
      round_sat = QMIN[DW-1:0];
    end else begin
      round_sat = quo[DW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Handshake and pipeline flow
  // ---------------------------------------------------------------------
  logic            busy_r;
  logic [PW-1:0]   phase_r;
  logic            phase_last;
  logic            v1_r, v2_r, v3_r, ov_r;
  logic            o_ready, s3_ready, s2_ready, s1_ready;
  logic            issue;
  logic            in_accept;
  logic            sym_accept;
  logic            tap_wr;
  logic [KW-1:0]   kp1;

  assign phase_last = (phase_r == PW'(SPS - 1));
  assign o_ready    = !ov_r || !out_stall;
  assign s3_ready   = !v3_r || o_ready;
  assign s2_ready   = !v2_r || s3_ready;
  assign s1_ready   = !v1_r || s2_ready;
  assign issue      = busy_r && s1_ready;

  // a new request is taken when idle, or alongside the last phase issue
  assign in_stall   = !(!busy_r || (phase_last && s1_ready));
  assign in_accept  = in_valid && !in_stall;
  assign sym_accept = in_accept && (in_item.command == psi_pkg::CMD_SYMBOL);
  assign kp1        = KW'(in_item.tap_index) + KW'(1);
  assign tap_wr     = in_accept && (in_item.command == psi_pkg::CMD_TAP_WRITE)
                      && (KW'(in_item.tap_index) < KW'(NTAPS));

  // phase sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= '0;
    end else if (sym_accept) begin
      busy_r  <= 1'b1;
      phase_r <= '0;
    end else if (issue) begin
      if (phase_last) begin
        busy_r  <= 1'b0;
        phase_r <= '0;
      end else begin
        phase_r <= phase_r + PW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Symbol history: entry 0 is the newest symbol
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] hist_i_r [LANES];
  logic signed [DW-1:0] hist_q_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < LANES; d++) begin
        hist_i_r[d] <= '0;
        hist_q_r[d] <= '0;
      end
    end else if (sym_accept) begin
      hist_i_r[0] <= in_item.sym_i;
      hist_q_r[0] <= in_item.sym_q;
      for (int d = 1; d < LANES; d++) begin
        hist_i_r[d] <= hist_i_r[d-1];
        hist_q_r[d] <= hist_q_r[d-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tap banks: tap k lives in bank (k+1)/SPS at word (k+1)%SPS, so phase p
  // of lane d reads tap d*SPS+p-1. Stage 1 is the registered bank read.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] s1_tap_r [LANES];

  for (genvar d = 0; d < LANES; d++) begin : g_bank
    logic [DW-1:0] mem [SPS];
    logic          wr_en;
    logic [KW-1:0] rel;

    assign rel   = kp1 - KW'(d * SPS);
    assign wr_en = tap_wr && (kp1 >= KW'(d * SPS)) && (kp1 < KW'((d + 1) * SPS));

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[rel[PW-1:0]] <= in_item.tap_value;
      end
      if (issue) begin
        s1_tap_r[d] <= mem[phase_r];
      end
    end
  end

  // lanes whose tap index falls outside the filter add nothing
  logic [LANES-1:0]     lane_live;
  logic [KW-1:0]        pos [LANES];

  always_comb begin
    for (int d = 0; d < LANES; d++) begin
      pos[d]       = KW'(d * SPS) + KW'(phase_r);
      lane_live[d] = (pos[d] >= KW'(1)) && (pos[d] <= KW'(NTAPS));
    end
  end

  logic signed [DW-1:0] s1_hist_i_r [LANES];
  logic signed [DW-1:0] s1_hist_q_r [LANES];
  logic [LANES-1:0]     s1_live_r;
  logic                 s1_last_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int d = 0; d < LANES; d++) begin
        s1_hist_i_r[d] <= hist_i_r[d];
        s1_hist_q_r[d] <= hist_q_r[d];
      end
      s1_live_r <= lane_live;
      s1_last_r <= phase_last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: one multiplier per lane and channel
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_i_r [LANES];
  logic signed [PROD_W-1:0] prod_q_r [LANES];
  logic                     s2_last_r;

  always_ff @(posedge clk) begin
    if (s2_ready && v1_r) begin
      for (int d = 0; d < LANES; d++) begin
        prod_i_r[d] <= s1_live_r[d] ? s1_tap_r[d] * s1_hist_i_r[d] : PROD_ZERO;
        prod_q_r[d] <= s1_live_r[d] ? s1_tap_r[d] * s1_hist_q_r[d] : PROD_ZERO;
      end
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: lane sum
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_i_nxt, sum_q_nxt;
  logic signed [SUM_W-1:0] sum_i_r, sum_q_r;
  logic                    s3_last_r;

  always_comb begin
    sum_i_nxt = '0;
    sum_q_nxt = '0;
    for (int d = 0; d < LANES; d++) begin
      sum_i_nxt = sum_i_nxt + SUM_W'(prod_i_r[d]);
      sum_q_nxt = sum_q_nxt + SUM_W'(prod_q_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && v2_r) begin
      sum_i_r   <= sum_i_nxt;
      sum_q_r   <= sum_q_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: round, saturate, output register
  // ---------------------------------------------------------------------
  psi_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (o_ready && v3_r) begin
      out_r.out_i <= round_sat(sum_i_r);
      out_r.out_q <= round_sat(sum_q_r);
      out_r.last  <= s3_last_r;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (s1_ready) v1_r <= issue;
      if (s2_ready) v2_r <= v1_r;
      if (s3_ready) v3_r <= v2_r;
      if (o_ready)  ov_r <= v3_r;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = out_r;

endmodule

// File: verif/tb_pulse_shaping_interpolator_unit.sv
// Self-checking testbench for pulse_shaping_interpolator_unit: tap loads and
// complex symbols in, shaped samples out, each checked against a local model.
// Depends on psi_pkg and the RTL top level only.
module tb_pulse_shaping_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS        = psi_pkg::SPS_DEF * psi_pkg::SPAN_DEF + 1;
  localparam int HDEPTH       = psi_pkg::SPAN_DEF + 1;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;  // longest legal quiet stretch is the receiver hold-off
  localparam int DRAIN_CYCLES = 32;    // covers the pipeline latency plus one full symbol
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the block
  localparam int HOLD_AT      = 300;   // sample count that triggers the hold-off
  localparam int PRINT_MAX    = 40;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  psi_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  psi_pkg::out_item_t out_item;

  pulse_shaping_interpolator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Local filter model: tap copy, symbol history and the queue of shaped
  // samples still owed by the block, oldest first.
  // ---------------------------------------------------------------------
  logic signed [psi_pkg::SAMPLE_W-1:0] coef_mem [NTAPS];
  logic signed [psi_pkg::SAMPLE_W-1:0] hist_i [HDEPTH];
  logic signed [psi_pkg::SAMPLE_W-1:0] hist_q [HDEPTH];
  psi_pkg::out_item_t                  shaped_q [$];
  psi_pkg::in_item_t                   pending [$];

  int mismatches      = 0;
  int samples_checked = 0;
  int symbols_sent    = 0;
  int taps_loaded     = 0;
  int taps_dropped    = 0;

  // Q34.30 accumulator -> Q1.15: round half up at bit 15, then clip.
  function automatic logic signed [psi_pkg::SAMPLE_W-1:0] round_to_q15(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[psi_pkg::SAMPLE_W-1:0];
  endfunction

  // Symbol request: shift history, then one sample per phase. The symbol
  // sits at phase 1 of its slot, hence tap index d*SPS + p - 1.
  task automatic shape_symbol(logic signed [psi_pkg::SAMPLE_W-1:0] si,
                              logic signed [psi_pkg::SAMPLE_W-1:0] sq);
    int                 p, d, k;
    longint             acc_i, acc_q;
    psi_pkg::out_item_t s;
    for (d = HDEPTH - 1; d > 0; d--) begin
      hist_i[d] = hist_i[d-1];
      hist_q[d] = hist_q[d-1];
    end
    hist_i[0] = si;
    hist_q[0] = sq;
    for (p = 0; p < psi_pkg::SPS_DEF; p++) begin
      acc_i = 0;
      acc_q = 0;
      for (d = 0; d < HDEPTH; d++) begin
        k = d * psi_pkg::SPS_DEF + p - 1;
        if (k >= 0 && k < NTAPS) begin
          acc_i += longint'(coef_mem[k]) * longint'(hist_i[d]);
          acc_q += longint'(coef_mem[k]) * longint'(hist_q[d]);
        end
      end
      s.out_i = round_to_q15(acc_i);
      s.out_q = round_to_q15(acc_q);
      s.last  = (p == psi_pkg::SPS_DEF - 1);
      shaped_q = {shaped_q, s};
    end
  endtask

  // Called for every request the block accepts.
  task automatic track_request(psi_pkg::in_item_t req);
    if (req.command == psi_pkg::CMD_TAP_WRITE) begin
      // indexes past the tap set are dropped by the block
      if (int'(req.tap_index) < NTAPS) begin
        coef_mem[req.tap_index] = req.tap_value;
        taps_loaded++;
      end else begin
        taps_dropped++;
      end
    end else begin
      shape_symbol(req.sym_i, req.sym_q);
      symbols_sent++;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_MAX)
      $display("[%0t] sample %0d: %s: got %0d, expected %0d",
               $realtime, samples_checked, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers. Fields a command does not use still get random bits.
  // ---------------------------------------------------------------------
  function automatic logic signed [psi_pkg::SAMPLE_W-1:0] pick_q15();
    unique case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3, 4: return 16'(int'($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic psi_pkg::in_item_t noise_req();
    psi_pkg::in_item_t req;
    req.command   = psi_pkg::CMD_SYMBOL;
    req.tap_index = 6'($urandom);
    req.tap_value = 16'($urandom);
    req.sym_i     = 16'($urandom);
    req.sym_q     = 16'($urandom);
    return req;
  endfunction

  function automatic void queue_tap(int idx, logic signed [psi_pkg::SAMPLE_W-1:0] val);
    psi_pkg::in_item_t req;
    req           = noise_req();
    req.command   = psi_pkg::CMD_TAP_WRITE;
    req.tap_index = idx[psi_pkg::IDX_W-1:0];
    req.tap_value = val;
    pending       = {pending, req};
  endfunction

  function automatic void queue_symbol(logic signed [psi_pkg::SAMPLE_W-1:0] si,
                                       logic signed [psi_pkg::SAMPLE_W-1:0] sq);
    psi_pkg::in_item_t req;
    req         = noise_req();
    req.command = psi_pkg::CMD_SYMBOL;
    req.sym_i   = si;
    req.sym_q   = sq;
    pending     = {pending, req};
  endfunction

  // Per-request (or per-sample) random wait, with occasional runs of
  // back-to-back requests so the block also sees full-rate traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued requests, holds the payload while stalled.
  // ---------------------------------------------------------------------
  int gap_left  = 0;
  int drv_calm  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        track_request(in_item);
      // slot is free if nothing was offered or the offer just went through
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_item  <= pending.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_wait(drv_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random stall per sample, one long hold-off, field checks.
  // ---------------------------------------------------------------------
  int                 hold_left = 0;
  int                 mon_calm  = 0;
  psi_pkg::out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shaped_q.size() == 0) begin
          report_mismatch("sample with none outstanding", int'(out_item.out_i), 0);
        end else begin
          want = shaped_q.pop_front();
          if (out_item.out_i !== want.out_i)
            report_mismatch("out_i", int'(out_item.out_i), int'(want.out_i));
          if (out_item.out_q !== want.out_q)
            report_mismatch("out_q", int'(out_item.out_q), int'(want.out_q));
          if (out_item.last !== want.last)
            report_mismatch("last", int'(out_item.last), int'(want.last));
        end
        samples_checked++;
        hold_left = draw_wait(mon_calm);
        // back-pressure test: sit on the output long enough that the
        // block fills and has to stall the sender
        if (samples_checked == HOLD_AT)
          hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any stretch with no handshake on either side this long
  // means the block has hung.
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no request moved for %0d cycles, %0d samples outstanding",
               $realtime, quiet_cycles, shaped_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    for (int k = 0; k < NTAPS; k++) begin
      coef_mem[k] = '0;
    end
    for (int d = 0; d < HDEPTH; d++) begin
      hist_i[d] = '0;
      hist_q[d] = '0;
    end

    // Every tap is loaded before the first symbol; unity taps make the
    // rounding visible.
    for (int k = 0; k < NTAPS; k++) begin
      queue_tap(k, 16'sd1);
    end

    // Directed: dropped indexes, half-LSB rounding both signs, extremes.
    queue_tap(NTAPS, 16'sh7fff);
    queue_tap(63, 16'sh8000);
    queue_symbol(16'sd16384, -16'sd16384);
    queue_symbol(16'sh8000, 16'sh7fff);
    queue_symbol(16'sh7fff, 16'sh8000);
    queue_symbol('0, '0);
    // all five taps of phase 1 at full negative scale, then a run of equal
    // symbols so the sums clip high on I and low on Q
    for (int d = 0; d < HDEPTH; d++) begin
      queue_tap(d * psi_pkg::SPS_DEF, 16'sh8000);
    end
    for (int n = 0; n < HDEPTH; n++) begin
      queue_symbol(16'sh8000, 16'sh7fff);
    end
    // tap changed between symbols, history carries on
    queue_tap(NTAPS - 1, 16'sh7fff);
    queue_symbol(16'sh7fff, 16'sh8000);

    // Random: fresh moderate tap set, then mostly symbols with some tap
    // rewrites at any index, in range or not.
    for (int k = 0; k < NTAPS; k++) begin
      queue_tap(k, 16'(int'($urandom_range(0, 16383)) - 8192));
    end
    for (int n = 0; n < 76; n++) begin
      if ($urandom_range(0, 7) == 0)
        queue_tap($urandom_range(0, 63), pick_q15());
      else
        queue_symbol(pick_q15(), pick_q15());
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sample on the falling edge so the check sees settled state
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || shaped_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d symbols, %0d tap loads and %0d dropped tap indexes,",
             symbols_sent, taps_loaded, taps_dropped);
    $display("with %0d shaped samples checked and %0d field errors.",
             samples_checked, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
